### hw/rtl/fmrc_pkg.sv
// Package with shared types, constants and rule field layout for the classifier.
package fmrc_pkg;

  localparam int RULES  = 16;
  localparam int ALGOS  = 8;
  localparam int PROTOS = 4;
  localparam int IDX_W  = $clog2(RULES);
  localparam int CNT_W  = $clog2(RULES + 1);

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_NOBUF  = 2'd2;

  localparam logic [1:0] WSEL_MIN = 2'd0;
  localparam logic [1:0] WSEL_MAX = 2'd1;
  localparam logic [1:0] WSEL_SEL = 2'd2;
  localparam logic [1:0] WSEL_FLT = 2'd3;

  localparam logic [1:0] CFG_NODES = 2'd0;
  localparam logic [1:0] CFG_RANKS = 2'd1;
  localparam logic [1:0] CFG_RULES = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int RULE_W     = 48 + 48 + 17 + 45;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  coll_type;
    logic [47:0] byte_count;
    logic [7:0]  pipe_ops;
    logic        reg_buff;
    logic [3:0]  algo_limit;
    logic [2:0]  proto_limit;
    logic [31:0] ignore_mask;
    logic [3:0]  rule_index;
    logic [1:0]  word_select;
    logic [63:0] rule_word;
  } cmd_t;

  typedef struct packed {
    logic        matched;
    logic [2:0]  algorithm;
    logic [1:0]  protocol;
    logic        override_channels;
    logic [6:0]  channel_count;
  } result_t;

  // Word as queued between the front and the back. Loads are queued too, so
  // they reach the table in order with the queries around them.
  typedef struct packed {
    logic        is_query;
    logic        check_buf;
    logic [3:0]  coll_type;
    logic [47:0] byte_count;
    logic [7:0]  pipe_ops;
    logic        reg_buff;
    logic [3:0]  algo_limit;
    logic [2:0]  proto_limit;
    logic [31:0] ignore_mask;
    logic        is_load;
    logic [3:0]  rule_index;
    logic [1:0]  word_select;
    logic [63:0] rule_word;
  } job_t;

  typedef struct packed {
    logic [47:0] min_bytes;
    logic [47:0] max_bytes;
    logic [16:0] selection;
    logic [44:0] filter;
  } rule_t;

endpackage

### hw/rtl/fmrc_ram.sv
// Generic single-port-write RAM with a registered read.
module fmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/fmrc_front.sv
// Front part: accepts words, performs rule loads, queues queries.
module fmrc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fmrc_pkg::cmd_t    cmd,
  input  logic              pop,
  output logic              busy,
  output logic              job_valid,
  output fmrc_pkg::job_t    job,
  output logic              load_we,
  output logic [1:0]        load_wsel,
  output logic [fmrc_pkg::IDX_W-1:0] load_idx,
  output logic [63:0]       load_word
);
  import fmrc_pkg::*;

  // Two-entry queue of jobs.
  job_t q [2];
  logic [1:0] fill;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];

  // A load is written when it leaves the queue, after every earlier query.
  assign load_we   = pop && job.is_load && ({1'b0, job.rule_index} < 5'(RULES));
  assign load_wsel = job.word_select;
  assign load_idx  = job.rule_index[IDX_W-1:0];
  assign load_word = job.rule_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        q[wr_ptr].is_query    <= (cmd.mode == MODE_QUERY) || (cmd.mode == MODE_NOBUF);
        q[wr_ptr].check_buf   <= (cmd.mode == MODE_QUERY);
        q[wr_ptr].coll_type   <= cmd.coll_type;
        q[wr_ptr].byte_count  <= cmd.byte_count;
        q[wr_ptr].pipe_ops    <= cmd.pipe_ops;
        q[wr_ptr].reg_buff    <= cmd.reg_buff;
        q[wr_ptr].algo_limit  <= cmd.algo_limit;
        q[wr_ptr].proto_limit <= cmd.proto_limit;
        q[wr_ptr].ignore_mask <= cmd.ignore_mask;
        q[wr_ptr].is_load     <= (cmd.mode == MODE_LOAD);
        q[wr_ptr].rule_index  <= cmd.rule_index;
        q[wr_ptr].word_select <= cmd.word_select;
        q[wr_ptr].rule_word   <= cmd.rule_word;
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hw/rtl/fmrc_back.sv
// Back part: scans the rule table for one queued query at a time.
module fmrc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  fmrc_pkg::job_t             job,
  output logic                       pop,
  output logic [fmrc_pkg::IDX_W-1:0] raddr,
  input  fmrc_pkg::rule_t            rule,
  input  logic [15:0]                node_count,
  input  logic [15:0]                rank_count,
  input  logic [4:0]                 rule_count,
  output logic                       done,
  output fmrc_pkg::result_t          result
);
  import fmrc_pkg::*;

  typedef enum logic [1:0] {IDLE, FETCH, CHECK} state_t;

  state_t            state;
  job_t              cur;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  limit;
  logic              hit;
  logic [2:0]        algo;
  logic [1:0]        proto;
  logic [4:0]        bitpos;
  logic              last;

  assign raddr = idx[IDX_W-1:0];
  assign pop   = (state == IDLE) && job_valid;
  assign algo  = rule.selection[6:4];
  assign proto = rule.selection[8:7];
  assign bitpos = 5'({2'b00, algo} * 5'(PROTOS) + {3'b000, proto});
  assign last  = (idx + CNT_W'(1)) >= limit;

  always_comb begin
    hit = (rule.selection[3:0] == cur.coll_type)
       && (cur.byte_count >= rule.min_bytes)
       && (cur.byte_count <= rule.max_bytes)
       && (rule.filter[16] || rule.filter[15:0] == node_count)
       && (rule.filter[33] || rule.filter[32:17] == rank_count)
       && (rule.filter[42] || rule.filter[41:34] == cur.pipe_ops)
       && (!cur.check_buf || rule.filter[44] || rule.filter[43] == cur.reg_buff)
       && ({1'b0, algo} < cur.algo_limit)
       && ({1'b0, proto} < cur.proto_limit)
       && !cur.ignore_mask[bitpos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            cur    <= job;
            idx    <= '0;
            result <= '0;
            limit  <= (rule_count > 5'(RULES)) ? CNT_W'(RULES) : CNT_W'(rule_count);
            if (job.is_query && rule_count != 5'd0) begin
              state <= FETCH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        FETCH: begin
          state <= CHECK;
        end
        CHECK: begin
          if (hit) begin
            result.matched           <= 1'b1;
            result.algorithm         <= algo;
            result.protocol          <= proto;
            result.override_channels <= rule.selection[9];
            result.channel_count     <= rule.selection[9] ? rule.selection[16:10] : 7'd0;
            done  <= 1'b1;
            state <= IDLE;
          end else if (last) begin
            done  <= 1'b1;
            state <= IDLE;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= FETCH;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/first_match_rule_classifier.sv
// Top level of the first-match rule classifier.
// A load or unused mode answers once the back takes it from the queue; a query
// reads and compares one rule at a time (registered table read, then compare)
// and scans up to 16 rules. The back takes one queued word at a time and starts
// the next only after the last is done; a two-word queue lets start be taken
// while a query scans. Reset clears registers to node_count=1, rank_count=1,
// rule_count=0; the rule table is undefined until loaded.
module first_match_rule_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  fmrc_pkg::cmd_t                  cmd,
  output logic                            busy,
  output logic                            done,
  output fmrc_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [fmrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fmrc_pkg::*;

  logic [15:0] node_count;
  logic [15:0] rank_count;
  logic [4:0]  rule_count;

  logic             job_valid;
  job_t             job;
  logic             pop;
  logic             load_we;
  logic [1:0]       load_wsel;
  logic [IDX_W-1:0] load_idx;
  logic [63:0]      load_word;
  logic [IDX_W-1:0] raddr;
  rule_t            rule;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 16'd1;
      rank_count <= 16'd1;
      rule_count <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODES: node_count <= cfg_data[15:0];
        CFG_RANKS: rank_count <= cfg_data[15:0];
        CFG_RULES: rule_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  fmrc_front u_front (
    .clk, .rst, .start, .cmd, .pop, .busy, .job_valid, .job,
    .load_we, .load_wsel, .load_idx, .load_word
  );

  fmrc_ram #(.WIDTH(48), .DEPTH(RULES)) u_min (
    .clk, .we(load_we && load_wsel == WSEL_MIN), .waddr(load_idx),
    .wdata(load_word[47:0]), .raddr, .rdata(rule.min_bytes)
  );
  fmrc_ram #(.WIDTH(48), .DEPTH(RULES)) u_max (
    .clk, .we(load_we && load_wsel == WSEL_MAX), .waddr(load_idx),
    .wdata(load_word[47:0]), .raddr, .rdata(rule.max_bytes)
  );
  fmrc_ram #(.WIDTH(17), .DEPTH(RULES)) u_sel (
    .clk, .we(load_we && load_wsel == WSEL_SEL), .waddr(load_idx),
    .wdata(load_word[16:0]), .raddr, .rdata(rule.selection)
  );
  fmrc_ram #(.WIDTH(45), .DEPTH(RULES)) u_flt (
    .clk, .we(load_we && load_wsel == WSEL_FLT), .waddr(load_idx),
    .wdata(load_word[44:0]), .raddr, .rdata(rule.filter)
  );

  fmrc_back u_back (
    .clk, .rst, .job_valid, .job, .pop, .raddr, .rule,
    .node_count, .rank_count, .rule_count, .done, .result
  );
endmodule

### tb/fmrc_checker.sv
// Checker for the classifier: predicts every result word and compares it.
`timescale 1ns / 100ps

module fmrc_checker
  import fmrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  cmd_t                  cmd,
  input  logic                  busy,
  input  logic                  done,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    errors
);

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic [47:0] min_tab [RULES];
  logic [47:0] max_tab [RULES];
  logic [16:0] sel_tab [RULES];
  logic [44:0] flt_tab [RULES];
  logic [15:0] nodes_cfg;
  logic [15:0] ranks_cfg;
  logic [4:0]  rules_cfg;
  result_t     expected_q [$];
  int          err_cnt;

  // First usable rule in table order, or an all-zero word.
  function automatic result_t classify(cmd_t c);
    result_t r;
    int      limit;
    logic [16:0] s;
    logic [44:0] f;
    logic [2:0]  algo;
    logic [1:0]  proto;
    r = '0;
    if (c.mode == MODE_LOAD || c.mode == MODE_UNUSED) return r;
    limit = (rules_cfg < RULES) ? rules_cfg : RULES;
    for (int i = 0; i < limit; i++) begin
      s = sel_tab[i];
      f = flt_tab[i];
      algo = s[6:4];
      proto = s[8:7];
      if (s[3:0] != c.coll_type) continue;
      if (c.byte_count < min_tab[i] || c.byte_count > max_tab[i]) continue;
      if (!f[16] && f[15:0] != nodes_cfg) continue;
      if (!f[33] && f[32:17] != ranks_cfg) continue;
      if (!f[42] && f[41:34] != c.pipe_ops) continue;
      if (c.mode == MODE_QUERY && !f[44] && f[43] != c.reg_buff) continue;
      if (algo >= c.algo_limit || proto >= c.proto_limit) continue;
      if (c.ignore_mask[algo * PROTOS + proto]) continue;
      r.matched = 1'b1;
      r.algorithm = algo;
      r.protocol = proto;
      r.override_channels = s[9];
      r.channel_count = s[9] ? s[16:10] : 7'd0;
      return r;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_w;
    if (rst) begin
      nodes_cfg = 16'd1;
      ranks_cfg = 16'd1;
      rules_cfg = 5'd0;
      expected_q.delete();
      err_cnt = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, result);
          err_cnt++;
        end else begin
          exp_w = expected_q.pop_front();
          if (result.matched !== exp_w.matched) begin
            $display("%0t: matched expected %h actual %h", $time, exp_w.matched,
                     result.matched);
            err_cnt++;
          end
          if (result.algorithm !== exp_w.algorithm) begin
            $display("%0t: algorithm expected %h actual %h", $time, exp_w.algorithm,
                     result.algorithm);
            err_cnt++;
          end
          if (result.protocol !== exp_w.protocol) begin
            $display("%0t: protocol expected %h actual %h", $time, exp_w.protocol,
                     result.protocol);
            err_cnt++;
          end
          if (result.override_channels !== exp_w.override_channels) begin
            $display("%0t: override_channels expected %h actual %h", $time,
                     exp_w.override_channels, result.override_channels);
            err_cnt++;
          end
          if (result.channel_count !== exp_w.channel_count) begin
            $display("%0t: channel_count expected %h actual %h", $time,
                     exp_w.channel_count, result.channel_count);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(classify(cmd));
        if (cmd.mode == MODE_LOAD) begin
          case (cmd.word_select)
            WSEL_MIN: min_tab[cmd.rule_index] = cmd.rule_word[47:0];
            WSEL_MAX: max_tab[cmd.rule_index] = cmd.rule_word[47:0];
            WSEL_SEL: sel_tab[cmd.rule_index] = cmd.rule_word[16:0];
            default:  flt_tab[cmd.rule_index] = cmd.rule_word[44:0];
          endcase
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODES: nodes_cfg = cfg_data[15:0];
          CFG_RANKS: ranks_cfg = cfg_data[15:0];
          CFG_RULES: rules_cfg = cfg_data[4:0];
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
    errors <= err_cnt;
  end

endmodule

### tb/testbench.sv
// Top of the classifier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import fmrc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  cmd_t                  cmd = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pending;
  int                    errors;
  int                    stall_cycles;
  int                    gap_pct;

  // Copy of what the table holds, used only to aim queries at rules.
  logic [47:0] aim_min [RULES];
  logic [47:0] aim_max [RULES];
  logic [16:0] aim_sel [RULES];
  logic [44:0] aim_flt [RULES];
  logic [15:0] cur_nodes;
  logic [15:0] cur_ranks;

  always #1 clk = ~clk;

  first_match_rule_classifier u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fmrc_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Noise in every field, so every bit toggles even on loads.
  function automatic cmd_t noise_word(logic [1:0] mode);
    cmd_t         c;
    logic [191:0] raw;
    raw = {rand64(), rand64(), rand64()};
    c = raw[$bits(cmd_t)-1:0];
    c.mode = mode;
    return c;
  endfunction

  // Issue one word and return at the edge where it is taken.
  task automatic send(cmd_t c);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      cmd <= noise_word(MODE_QUERY);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_word(int slot, logic [1:0] wsel, logic [63:0] w);
    cmd_t c;
    c = noise_word(MODE_LOAD);
    c.rule_index = 4'(slot);
    c.word_select = wsel;
    c.rule_word = w;
    case (wsel)
      WSEL_MIN: aim_min[slot] = w[47:0];
      WSEL_MAX: aim_max[slot] = w[47:0];
      WSEL_SEL: aim_sel[slot] = w[16:0];
      default:  aim_flt[slot] = w[44:0];
    endcase
    send(c);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_NODES) cur_nodes = val;
    if (idx == CFG_RANKS) cur_ranks = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A rule likely to be hit under the current node and rank counts.
  task automatic load_random_rule(int slot, bit one_word);
    logic [47:0] lo, hi, t;
    logic [16:0] s;
    logic [44:0] f;
    logic [63:0] w [4];
    int          k;
    lo = 48'(rand64() >> $urandom_range(16, 63));
    hi = lo + 48'(rand64() >> $urandom_range(16, 63));
    if (hi < lo || $urandom_range(19) == 0) begin
      t = lo; lo = hi; hi = t;
    end
    if ($urandom_range(9) == 0) hi = '1;
    s = {7'($urandom()), 1'($urandom()), 2'($urandom()), 3'($urandom()),
         4'($urandom_range(3))};
    f[16] = 1'($urandom_range(1));
    f[15:0] = $urandom_range(2) ? cur_nodes : 16'($urandom());
    f[33] = 1'($urandom_range(1));
    f[32:17] = $urandom_range(2) ? cur_ranks : 16'($urandom());
    f[42] = 1'($urandom_range(1));
    f[41:34] = 8'($urandom());
    f[44:43] = 2'($urandom());
    w[0] = {16'(rand64()), lo};
    w[1] = {16'(rand64()), hi};
    w[2] = {47'(rand64()), s};
    w[3] = {19'(rand64()), f};
    if (one_word) begin
      k = $urandom_range(3);
      load_word(slot, 2'(k), $urandom_range(7) == 0 ? rand64() : w[k]);
    end else begin
      for (int i = 0; i < 4; i++) load_word(slot, 2'(i), w[i]);
    end
  endtask

  // A query aimed at one rule, with the limits and mask mostly open.
  function automatic cmd_t aimed_query();
    cmd_t        c;
    int          r;
    logic [63:0] span;
    c = noise_word($urandom_range(1) ? MODE_QUERY : MODE_NOBUF);
    r = $urandom_range(RULES - 1);
    if ($urandom_range(9) < 8) begin
      c.coll_type = aim_sel[r][3:0];
      c.pipe_ops = aim_flt[r][41:34];
      c.reg_buff = aim_flt[r][43];
      if (aim_max[r] >= aim_min[r]) begin
        span = 64'(aim_max[r]) - 64'(aim_min[r]) + 64'd1;
        c.byte_count = aim_min[r] + 48'(rand64() % span);
      end
    end
    c.algo_limit = $urandom_range(9) < 7 ? 4'd8 : 4'($urandom());
    c.proto_limit = $urandom_range(9) < 7 ? 3'd4 : 3'($urandom());
    case ($urandom_range(9))
      0, 1:    c.ignore_mask = 32'd1 << $urandom_range(31);
      2:       c.ignore_mask = $urandom();
      default: c.ignore_mask = '0;
    endcase
    return c;
  endfunction

  initial begin
    cmd_t        c;
    int          n_items;
    logic [15:0] phase_cfg [6][3];
    phase_cfg = '{'{16'd1, 16'd1, 16'd16}, '{16'hFFFF, 16'hFFFF, 16'd31},
                  '{16'd1000, 16'd7, 16'd5}, '{16'd42, 16'hFFFF, 16'd0},
                  '{16'hFFFF, 16'd1, 16'd16}, '{16'd3, 16'd12, 16'd17}};
    gap_pct = 24;
    cur_nodes = 16'd1;
    cur_ranks = 16'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table first, so no query ever reads an empty slot.
    for (int i = 0; i < RULES; i++) load_random_rule(i, 1'b0);

    // No rules in use: every query misses.
    c = aimed_query();
    send(c);
    write_reg(CFG_RULES, 16'd16);

    // Rule 0 matches anything of type 5 with algorithm 7, protocol 3.
    load_word(0, WSEL_MIN, 64'd0);
    load_word(0, WSEL_MAX, '1);
    load_word(0, WSEL_SEL, {47'd0, 7'd127, 1'b1, 2'd3, 3'd7, 4'd5});
    load_word(0, WSEL_FLT, {19'd0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b1, 16'd0, 1'b1, 16'd0});
    // Rule 1 has exact fields and a channel count with no override.
    load_word(1, WSEL_SEL, {47'h7FFF, 7'd127, 1'b0, 2'd0, 3'd0, 4'd5});
    load_word(1, WSEL_FLT, {19'd0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b0, 16'd1, 1'b0, 16'd1});
    load_word(1, WSEL_MIN, 64'd0);
    load_word(1, WSEL_MAX, {16'hFFFF, 48'hFFFF_FFFF_FFFF});
    for (int d = 0; d < 10; d++) begin
      c = noise_word(d == 8 ? MODE_UNUSED : (d == 9 ? MODE_NOBUF : MODE_QUERY));
      c.coll_type = 4'd5;
      c.byte_count = d[0] ? '1 : '0;
      c.pipe_ops = 8'hFF;
      c.reg_buff = 1'b1;
      c.algo_limit = d == 2 ? 4'd7 : (d == 5 ? 4'd0 : 4'd8);
      c.proto_limit = d == 3 ? 3'd3 : (d == 6 ? 3'd0 : 3'd4);
      c.ignore_mask = d == 4 ? 32'h8000_0000 : (d == 7 ? '1 : '0);
      if (d == 9) c.reg_buff = 1'b0;
      send(c);
    end

    n_items = 0;
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 3; k++) write_reg(2'(k), phase_cfg[p][k]);
      if (p == 5) begin
        write_reg(CFG_NODES, 16'($urandom_range(1, 65535)));
        write_reg(CFG_RANKS, 16'($urandom_range(1, 65535)));
      end
      for (int i = 0; i < 205; i++) begin
        gap_pct = n_items < 410 ? 24 : (n_items < 820 ? 60 : 0);
        // Short stretches with no gaps at all.
        if (n_items % 100 > 85) gap_pct = 0;
        case ($urandom_range(19))
          0, 1, 2: load_random_rule($urandom_range(RULES - 1), 1'b1);
          3:       send(noise_word(MODE_UNUSED));
          4:       send(noise_word(2'($urandom_range(1, 2))));
          default: send(aimed_query());
        endcase
        n_items++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fmrc_pkg.sv
hw/rtl/fmrc_ram.sv
hw/rtl/fmrc_front.sv
hw/rtl/fmrc_back.sv
hw/rtl/first_match_rule_classifier.sv
tb/fmrc_checker.sv
tb/testbench.sv
